### sv/rcpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpa_pkg
// Shared types, sizes and codes of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rcpa_pkg;

    // Sizes of the managed pool
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int COUNT_BITS = 8;

    localparam int IDX_W     = $clog2(NUM_PAGES);
    localparam int DEPTH_W   = $clog2(NUM_PAGES + 1);
    localparam int ADDR_W    = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int REF_OUT_W = 8;
    localparam int CMP_W     = ADDR_W + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [ADDR_W-1:0]     OFFSET_MASK =
        ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

    // Configuration registers
    localparam int MEM_BASE_W = 20;
    localparam int KEND_W     = 20;
    localparam int TOP_W      = 21;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_MEM_BASE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_END = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOP        = 2'd2;

    localparam logic [MEM_BASE_W-1:0] MEM_BASE_RST = 20'd524288;
    localparam logic [KEND_W-1:0]     KEND_RST     = 20'd524288;
    localparam logic [TOP_W-1:0]      TOP_RST      = 21'd557056;

    // Operation modes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REFUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEED  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BADADDR = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_UNDER   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SAT     = 3'd4;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [MEM_BASE_W-1:0] mem_base_page;
        logic [KEND_W-1:0]     kernel_end_page;
        logic [TOP_W-1:0]      top_page;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              bad;
        logic [IDX_W-1:0]  idx;
    } q_entry_t;

endpackage

### sv/refcounted_page_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit
// Physical page allocator with per-page reference counts and a LIFO free list.
// ----------------------------------------------------------------------------
// Each item carries a mode (allocate, free, reference up, query, seed) and a
// page-aligned physical address; each item returns exactly one result with a
// status, the allocated page address, the page's count after the operation
// and a released flag. The address is checked for every mode, allocate
// included. After reset the count table is cleared one entry per cycle;
// s_ready stays low during that pass, while configuration writes are taken
// at any time. Afterwards the back end first reads the count RAM and the
// free-stack RAM for an item, then writes them back and loads the result
// register; it does not start the next item before that write-back. A
// two-entry queue lets the front keep accepting while the back end works or
// the result waits to be taken.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rcpa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rcpa_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rcpa_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,

    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rcpa_pkg::MODE_W-1:0]         s_mode,
    input  logic [rcpa_pkg::ADDR_W-1:0]         s_addr,

    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rcpa_pkg::STATUS_W-1:0]       m_status,
    output logic [rcpa_pkg::ADDR_W-1:0]         m_page_addr,
    output logic [rcpa_pkg::REF_OUT_W-1:0]      m_ref_count,
    output logic                                m_released
);

    rcpa_pkg::cfg_t                     cfg_reg;
    logic [rcpa_pkg::REG_IDX_W-1:0]     reg_idx;
    logic                               cfg_wr;

    logic                               clearing;
    logic                               q_full;
    logic                               q_push;
    logic                               q_pop;
    logic                               q_valid;
    rcpa_pkg::q_entry_t                 q_in;
    rcpa_pkg::q_entry_t                 q_out;

    // Register file: word addresses, no wait states.
    assign pready  = 1'b1;
    assign reg_idx = paddr[rcpa_pkg::CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mem_base_page   <= rcpa_pkg::MEM_BASE_RST;
            cfg_reg.kernel_end_page <= rcpa_pkg::KEND_RST;
            cfg_reg.top_page        <= rcpa_pkg::TOP_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                rcpa_pkg::REG_MEM_BASE: begin
                    cfg_reg.mem_base_page <= pwdata[rcpa_pkg::MEM_BASE_W-1:0];
                end
                rcpa_pkg::REG_KERNEL_END: begin
                    cfg_reg.kernel_end_page <= pwdata[rcpa_pkg::KEND_W-1:0];
                end
                rcpa_pkg::REG_TOP: begin
                    cfg_reg.top_page <= pwdata[rcpa_pkg::TOP_W-1:0];
                end
                default: begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rcpa_pkg::REG_MEM_BASE:
                prdata = rcpa_pkg::CFG_DATA_W'(cfg_reg.mem_base_page);
            rcpa_pkg::REG_KERNEL_END:
                prdata = rcpa_pkg::CFG_DATA_W'(cfg_reg.kernel_end_page);
            rcpa_pkg::REG_TOP:
                prdata = rcpa_pkg::CFG_DATA_W'(cfg_reg.top_page);
            default:
                prdata = '0;
        endcase
    end

    // Front: check and classify each item, then hand it to the queue.
    rcpa_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_mode),
        .s_addr   (s_addr),
        .cfg      (cfg_reg),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    // Queue: decouple acceptance from execution.
    rcpa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .entry_in  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .entry_out (q_out)
    );

    // Back: read-modify-write of count table and free stack, result register.
    rcpa_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_entry     (q_out),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_page_addr (m_page_addr),
        .m_ref_count (m_ref_count),
        .m_released  (m_released)
    );

endmodule

### sv/rcpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/rcpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpa_front
// Accepts items, checks address and mode, and pushes them into the queue.
// ----------------------------------------------------------------------------
module rcpa_front (
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rcpa_pkg::MODE_W-1:0]  s_mode,
    input  logic [rcpa_pkg::ADDR_W-1:0]  s_addr,
    input  rcpa_pkg::cfg_t               cfg,
    input  logic                         clearing,
    input  logic                         q_full,
    output logic                         q_push,
    output rcpa_pkg::q_entry_t           q_entry
);

    logic                         aligned;
    logic                         in_range;
    logic                         mode_ok;
    logic [rcpa_pkg::CMP_W-1:0]   page;
    logic [rcpa_pkg::CMP_W-1:0]   base;
    logic [rcpa_pkg::CMP_W-1:0]   diff;

    always_comb begin
        aligned  = (s_addr & rcpa_pkg::OFFSET_MASK) == '0;
        page     = rcpa_pkg::CMP_W'(s_addr >> rcpa_pkg::PAGE_SHIFT);
        base     = rcpa_pkg::CMP_W'(cfg.mem_base_page);
        diff     = page - base;
        in_range = (page >= rcpa_pkg::CMP_W'(cfg.kernel_end_page))
                && (page <  rcpa_pkg::CMP_W'(cfg.top_page))
                && (page >= base)
                && (diff <  rcpa_pkg::CMP_W'(rcpa_pkg::NUM_PAGES));
        mode_ok  = s_mode <= rcpa_pkg::MODE_SEED;
    end

    assign s_ready      = !clearing && !q_full;
    assign q_push       = s_valid && s_ready;
    assign q_entry.mode = s_mode;
    assign q_entry.bad  = !(aligned && in_range && mode_ok);
    assign q_entry.idx  = rcpa_pkg::IDX_W'(diff);

endmodule

### sv/rcpa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpa_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module rcpa_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  rcpa_pkg::q_entry_t   entry_in,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output rcpa_pkg::q_entry_t   entry_out
);

    rcpa_pkg::q_entry_t               entries_reg [rcpa_pkg::QDEPTH];
    logic [rcpa_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rcpa_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rcpa_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    localparam logic [rcpa_pkg::QPTR_W-1:0] PTR_LAST =
        rcpa_pkg::QPTR_W'(rcpa_pkg::QDEPTH - 1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= entry_in;
        end
    end

    assign full      = cnt_reg == rcpa_pkg::QCNT_W'(rcpa_pkg::QDEPTH);
    assign valid     = cnt_reg != '0;
    assign entry_out = entries_reg[rd_ptr_reg];

endmodule

### sv/rcpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpa_back
// Executes queued items against the count table and free stack; clears the
// count table after reset; holds the result register.
// ----------------------------------------------------------------------------
module rcpa_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rcpa_pkg::cfg_t                  cfg,
    input  logic                            q_valid,
    input  rcpa_pkg::q_entry_t              q_entry,
    output logic                            q_pop,
    output logic                            clearing,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rcpa_pkg::STATUS_W-1:0]   m_status,
    output logic [rcpa_pkg::ADDR_W-1:0]     m_page_addr,
    output logic [rcpa_pkg::REF_OUT_W-1:0]  m_ref_count,
    output logic                            m_released
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    localparam logic [rcpa_pkg::IDX_W-1:0] CLR_LAST =
        rcpa_pkg::IDX_W'(rcpa_pkg::NUM_PAGES - 1);
    localparam logic [rcpa_pkg::DEPTH_W-1:0] DEPTH_FULL =
        rcpa_pkg::DEPTH_W'(rcpa_pkg::NUM_PAGES);

    logic [1:0]                            state_reg, state_next;
    logic [rcpa_pkg::IDX_W-1:0]            clr_idx_reg, clr_idx_next;
    logic [rcpa_pkg::DEPTH_W-1:0]          depth_reg, depth_next;
    rcpa_pkg::q_entry_t                    op_reg, op_next;
    logic                                  m_valid_reg, m_valid_next;
    logic [rcpa_pkg::STATUS_W-1:0]         m_status_reg;
    logic [rcpa_pkg::ADDR_W-1:0]           m_page_addr_reg;
    logic [rcpa_pkg::REF_OUT_W-1:0]        m_ref_count_reg;
    logic                                  m_released_reg;

    logic                                  load_out;
    logic [rcpa_pkg::STATUS_W-1:0]         res_status;
    logic [rcpa_pkg::ADDR_W-1:0]           res_paddr;
    logic [rcpa_pkg::COUNT_BITS-1:0]       res_count;
    logic                                  res_rel;
    logic [63:0]                           pa_wide;
    logic                                  can_push;

    logic                                  cnt_we, cnt_re;
    logic [rcpa_pkg::IDX_W-1:0]            cnt_waddr, cnt_raddr;
    logic [rcpa_pkg::COUNT_BITS-1:0]       cnt_wdata, cnt_rd;
    logic                                  stk_we, stk_re;
    logic [rcpa_pkg::IDX_W-1:0]            stk_waddr, stk_raddr;
    logic [rcpa_pkg::IDX_W-1:0]            stk_wdata, stk_rd;

    rcpa_ram #(
        .WIDTH (rcpa_pkg::COUNT_BITS),
        .DEPTH (rcpa_pkg::NUM_PAGES)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rd)
    );

    rcpa_ram #(
        .WIDTH (rcpa_pkg::IDX_W),
        .DEPTH (rcpa_pkg::NUM_PAGES)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rd)
    );

    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        depth_next   = depth_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        load_out     = 1'b0;

        cnt_we    = 1'b0;
        cnt_waddr = op_reg.idx;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = q_entry.idx;
        stk_we    = 1'b0;
        stk_waddr = rcpa_pkg::IDX_W'(depth_reg);
        stk_wdata = op_reg.idx;
        stk_re    = 1'b0;
        stk_raddr = rcpa_pkg::IDX_W'(depth_reg - 1'b1);

        res_status = rcpa_pkg::STAT_OK;
        res_paddr  = '0;
        res_count  = '0;
        res_rel    = 1'b0;
        pa_wide    = 64'(rcpa_pkg::IDX_W'(stk_rd)) + 64'(cfg.mem_base_page);
        can_push   = depth_reg < DEPTH_FULL;

        unique case (state_reg)
            ST_CLEAR: begin
                cnt_we       = 1'b1;
                cnt_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // start only when the result register will be free
                if (q_valid && (!m_valid_reg || m_ready)) begin
                    q_pop      = 1'b1;
                    op_next    = q_entry;
                    cnt_re     = 1'b1;
                    stk_re     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                load_out     = 1'b1;
                if (op_reg.bad) begin
                    res_status = rcpa_pkg::STAT_BADADDR;
                end else begin
                    unique case (op_reg.mode)
                        rcpa_pkg::MODE_ALLOC: begin
                            if (depth_reg == '0) begin
                                res_status = rcpa_pkg::STAT_EMPTY;
                            end else begin
                                depth_next = depth_reg - 1'b1;
                                cnt_we     = 1'b1;
                                cnt_waddr  = stk_rd;
                                cnt_wdata  = rcpa_pkg::COUNT_BITS'(1);
                                res_count  = rcpa_pkg::COUNT_BITS'(1);
                                res_paddr  = rcpa_pkg::ADDR_W'(
                                    pa_wide << rcpa_pkg::PAGE_SHIFT);
                            end
                        end
                        rcpa_pkg::MODE_FREE: begin
                            if (cnt_rd == '0) begin
                                res_status = rcpa_pkg::STAT_UNDER;
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_rd - 1'b1;
                                res_count = cnt_rd - 1'b1;
                                if ((cnt_wdata == '0) && can_push) begin
                                    stk_we     = 1'b1;
                                    depth_next = depth_reg + 1'b1;
                                    res_rel    = 1'b1;
                                end
                            end
                        end
                        rcpa_pkg::MODE_REFUP: begin
                            if (cnt_rd == rcpa_pkg::COUNT_MAX) begin
                                res_status = rcpa_pkg::STAT_SAT;
                                res_count  = cnt_rd;
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_rd + 1'b1;
                                res_count = cnt_rd + 1'b1;
                            end
                        end
                        rcpa_pkg::MODE_QUERY: begin
                            res_count = cnt_rd;
                        end
                        rcpa_pkg::MODE_SEED: begin
                            // count forced to one, then dropped back to zero
                            cnt_we = 1'b1;
                            if (can_push) begin
                                stk_we     = 1'b1;
                                depth_next = depth_reg + 1'b1;
                                res_rel    = 1'b1;
                            end
                        end
                        default: begin
                            res_status = rcpa_pkg::STAT_BADADDR;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        if (load_out) begin
            m_status_reg    <= res_status;
            m_page_addr_reg <= res_paddr;
            m_ref_count_reg <= rcpa_pkg::REF_OUT_W'(res_count);
            m_released_reg  <= res_rel;
        end
    end

    assign clearing    = state_reg == ST_CLEAR;
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_page_addr = m_page_addr_reg;
    assign m_ref_count = m_ref_count_reg;
    assign m_released  = m_released_reg;

    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("executed item did not land in the result register");

    a_pop_starts_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == ST_EXEC)
        else $error("popped item not executed");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_FULL)
        else $error("free stack depth beyond pool size");

    a_depth_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (depth_reg == $past(depth_reg))
              || (depth_reg == $past(depth_reg) + 1'b1)
              || (depth_reg + 1'b1 == $past(depth_reg)))
        else $error("free stack depth moved by more than one");

endmodule

### dv/refcounted_page_allocator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit_test
// Self-checking bench for the reference-counted page allocator.
// ----------------------------------------------------------------------------
// Drive items through the valid/ready input channel and check every result
// against a local model of the count table and the LIFO free list. A short
// table of directed items covers reset state, address extremes, unknown modes
// and the empty, bad-address and underflow codes. Random items follow under
// several register settings, with a long result hold-off and one page driven
// into saturation. The run ends with a short stretch of random items under
// the reset settings, with no idling on either side.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_unit_test;
    import rcpa_pkg::*;

    localparam int unsigned     LONG_HOLD    = 300;
    localparam int unsigned     MAX_PRINTS   = 100;
    localparam int unsigned     TOP_LIMIT    = 1048576;
    localparam int unsigned     NUM_PROBES   = 24;
    localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;
    localparam logic [ADDR_W-1:0] POOL_FIRST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] POOL_LAST  = 32'h87FF_F000;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_W-1:0]    page_addr;
        logic [REF_OUT_W-1:0] ref_count;
        logic                 released;
    } page_result_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic              known;
        page_result_t      want;
    } probe_t;

    // Results that can be read straight off the spec
    localparam page_result_t ANY_RESULT = '0;
    localparam page_result_t R_ZERO   = '{STAT_OK, '0, '0, 1'b0};
    localparam page_result_t R_PUSHED = '{STAT_OK, '0, '0, 1'b1};
    localparam page_result_t R_EMPTY  = '{STAT_EMPTY, '0, '0, 1'b0};
    localparam page_result_t R_BAD    = '{STAT_BADADDR, '0, '0, 1'b0};
    localparam page_result_t R_UNDER  = '{STAT_UNDER, '0, '0, 1'b0};

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode  = '0;
    logic [ADDR_W-1:0]     s_addr  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [ADDR_W-1:0]     m_page_addr;
    logic [REF_OUT_W-1:0]  m_ref_count;
    logic                  m_released;

    // Bench control
    logic        idle_on      = 1'b0;
    logic        hold_off_req = 1'b0;
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;

    // Local copy of the allocator state
    cfg_t                  model_cfg;
    logic [COUNT_BITS-1:0] page_refs  [NUM_PAGES];
    logic [IDX_W-1:0]      free_pages [NUM_PAGES];
    int unsigned           free_depth;

    page_result_t pending_results [$];
    probe_t       probe_table [NUM_PROBES];

    refcounted_page_allocator_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_addr      (s_addr),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_page_addr (m_page_addr),
        .m_ref_count (m_ref_count),
        .m_released  (m_released)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        if (mismatches < MAX_PRINTS) begin
            $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                     $realtime, results_seen, what, got, want);
        end
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Model of the allocator
    // ------------------------------------------------------------------------

    // Drop one reference from a nonzero count; push the page once it hits zero,
    // unless the free list is already full.
    function automatic logic drop_page_ref(input logic [IDX_W-1:0] idx);
        page_refs[idx] = page_refs[idx] - 1'b1;
        if (page_refs[idx] != '0) return 1'b0;
        if (free_depth >= NUM_PAGES) return 1'b0;
        free_pages[free_depth] = idx;
        free_depth++;
        return 1'b1;
    endfunction

    function automatic page_result_t apply_page_op(input logic [MODE_W-1:0] mode,
                                                   input logic [ADDR_W-1:0] addr);
        page_result_t     res;
        longint unsigned  pg;
        logic [63:0]      wide_addr;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] popped;
        logic             in_range;
        res = '0;
        pg = addr >> PAGE_SHIFT;
        in_range = ((addr & OFFSET_MASK) == '0)
                   && pg >= model_cfg.kernel_end_page && pg < model_cfg.top_page
                   && pg >= model_cfg.mem_base_page
                   && (pg - model_cfg.mem_base_page) < NUM_PAGES;
        idx = IDX_W'(pg - model_cfg.mem_base_page);
        if (mode > MODE_SEED || !in_range) begin
            res.status = STAT_BADADDR;
        end else begin
            case (mode)
                MODE_ALLOC: begin
                    if (free_depth == 0) begin
                        res.status = STAT_EMPTY;
                    end else begin
                        free_depth--;
                        popped = free_pages[free_depth];
                        page_refs[popped] = 1;
                        res.ref_count = 1;
                        wide_addr = (64'(popped) + 64'(model_cfg.mem_base_page))
                                    << PAGE_SHIFT;
                        res.page_addr = wide_addr[ADDR_W-1:0];
                    end
                end
                MODE_FREE: begin
                    if (page_refs[idx] == '0) begin
                        res.status = STAT_UNDER;
                    end else begin
                        res.released = drop_page_ref(idx);
                        res.ref_count = REF_OUT_W'(page_refs[idx]);
                    end
                end
                MODE_REFUP: begin
                    if (page_refs[idx] >= COUNT_MAX) res.status = STAT_SAT;
                    else page_refs[idx] = page_refs[idx] + 1'b1;
                    res.ref_count = REF_OUT_W'(page_refs[idx]);
                end
                MODE_QUERY: begin
                    res.ref_count = REF_OUT_W'(page_refs[idx]);
                end
                default: begin
                    // seed: force the count to one, then free it onto the list
                    page_refs[idx] = 1;
                    res.released = drop_page_ref(idx);
                    res.ref_count = REF_OUT_W'(page_refs[idx]);
                end
            endcase
        end
        return res;
    endfunction

    // Pages that pass every address check under the current settings: [lo, hi)
    function automatic void page_window(output longint unsigned lo,
                                        output longint unsigned hi);
        longint unsigned table_end;
        lo = (model_cfg.kernel_end_page > model_cfg.mem_base_page) ?
             model_cfg.kernel_end_page : model_cfg.mem_base_page;
        table_end = longint'(model_cfg.mem_base_page) + NUM_PAGES;
        hi = (model_cfg.top_page < table_end) ? model_cfg.top_page : table_end;
    endfunction

    // Mostly a small cluster at the low end so that pages get reused;
    // sometimes the high end or anywhere in the window.
    function automatic logic [ADDR_W-1:0] valid_page_addr();
        longint unsigned lo, hi, span, cluster, pg;
        page_window(lo, hi);
        if (lo >= hi) return ADDR_W'($urandom()) & ~OFFSET_MASK;
        span = hi - lo;
        cluster = (span < 12) ? span : 12;
        case ($urandom_range(0, 9))
            0:       pg = lo + $urandom_range(0, 32'(span - 1));
            1:       pg = hi - 1 - $urandom_range(0, 32'(cluster - 1));
            default: pg = lo + $urandom_range(0, 32'(cluster - 1));
        endcase
        return ADDR_W'(pg << PAGE_SHIFT);
    endfunction

    function automatic logic [ADDR_W-1:0] noise_addr();
        longint unsigned lo, hi;
        page_window(lo, hi);
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return valid_page_addr() | ADDR_W'($urandom_range(1, OFFSET_MASK));
            2:       return ADDR_W'((lo - 1) << PAGE_SHIFT);
            default: return ADDR_W'(hi << PAGE_SHIFT);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one item, hold it until accepted, then log what it should return.
    // A typed expectation replaces the predicted one, but the model still
    // advances.
    task automatic push_item(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                             input logic use_want, input page_result_t want);
        page_result_t predicted;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            s_mode  = MODE_W'($urandom());
            s_addr  = $urandom();
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_mode  = mode;
        s_addr  = addr;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = apply_page_op(mode, addr);
        pending_results.push_back(use_want ? want : predicted);
    endtask

    task automatic push_mix(input int unsigned count);
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)      push_item(MODE_SEED, valid_page_addr(), 1'b0, ANY_RESULT);
            else if (pick < 34) push_item(MODE_ALLOC, valid_page_addr(), 1'b0, ANY_RESULT);
            else if (pick < 55) push_item(MODE_FREE, valid_page_addr(), 1'b0, ANY_RESULT);
            else if (pick < 68) push_item(MODE_REFUP, valid_page_addr(), 1'b0, ANY_RESULT);
            else if (pick < 78) push_item(MODE_QUERY, valid_page_addr(), 1'b0, ANY_RESULT);
            else push_item(MODE_W'($urandom_range(0, 7)), noise_addr(), 1'b0, ANY_RESULT);
        end
    endtask

    // Drop valid and wait until every outstanding result has been taken.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_access(input logic [REG_IDX_W-1:0] reg_idx, input logic wr,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = CFG_ADDR_W'({reg_idx, 2'b00});
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic cfg_verify(input logic [REG_IDX_W-1:0] reg_idx,
                              input logic [CFG_DATA_W-1:0] want);
        logic [CFG_DATA_W-1:0] rdata;
        cfg_access(reg_idx, 1'b0, '0, rdata);
        if (rdata !== want) report_mismatch("register readback", rdata, want);
    endtask

    task automatic cfg_write(input logic [REG_IDX_W-1:0] reg_idx,
                             input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] unused;
        cfg_access(reg_idx, 1'b1, value, unused);
        case (reg_idx)
            REG_MEM_BASE:   model_cfg.mem_base_page   = value[MEM_BASE_W-1:0];
            REG_KERNEL_END: model_cfg.kernel_end_page = value[KEND_W-1:0];
            default:        model_cfg.top_page        = value[TOP_W-1:0];
        endcase
        cfg_verify(reg_idx, value);
    endtask

    task automatic set_config(input int unsigned base, input int unsigned kend,
                              input int unsigned top);
        settle();
        cfg_write(REG_MEM_BASE, base);
        cfg_write(REG_KERNEL_END, kend);
        cfg_write(REG_TOP, top);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready with bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------
    always begin : result_sink
        @(negedge aclk);
        if (hold_off_req) begin
            // hold ready low long enough for the block to back up into s_ready
            m_ready = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge aclk);
            hold_off_req = 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation, field by field
    always @(posedge aclk) begin : result_check
        page_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, status", m_status, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_page_addr !== want.page_addr)
                    report_mismatch("page_addr", m_page_addr, want.page_addr);
                if (m_ref_count !== want.ref_count)
                    report_mismatch("ref_count", m_ref_count, want.ref_count);
                if (m_released !== want.released)
                    report_mismatch("released", m_released, want.released);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [ADDR_W-1:0] sat_addr;
        int unsigned       base, kend, top;

        // Under the reset settings the pool is pages 0x80000..0x87FFF.
        probe_table = '{
            '{MODE_ALLOC,   POOL_FIRST,    1'b1, R_EMPTY},   // empty list
            '{MODE_QUERY,   POOL_FIRST,    1'b1, R_ZERO},    // table cleared
            '{MODE_FREE,    POOL_FIRST,    1'b1, R_UNDER},   // free at zero
            '{MODE_REFUP,   32'h8000_0800, 1'b1, R_BAD},     // misaligned
            '{MODE_ALLOC,   32'h8000_0001, 1'b1, R_BAD},     // allocate is checked too
            '{MODE_QUERY,   32'h7FFF_F000, 1'b1, R_BAD},     // below kernel end
            '{MODE_SEED,    32'h8800_0000, 1'b1, R_BAD},     // page equal to top
            '{MODE_QUERY,   POOL_LAST,     1'b1, R_ZERO},    // last managed page
            '{MODE_RSVD_LO, POOL_FIRST,    1'b1, R_BAD},     // unknown modes
            '{MODE_RSVD_HI, POOL_FIRST,    1'b1, R_BAD},
            '{MODE_QUERY,   32'hFFFF_FFFF, 1'b1, R_BAD},
            '{MODE_QUERY,   32'h0000_0000, 1'b1, R_BAD},
            '{MODE_SEED,    POOL_FIRST,    1'b1, R_PUSHED},
            '{MODE_SEED,    POOL_LAST,     1'b1, R_PUSHED},
            '{MODE_ALLOC,   POOL_FIRST,    1'b0, ANY_RESULT}, // pops the last page
            '{MODE_REFUP,   POOL_LAST,     1'b0, ANY_RESULT},
            '{MODE_FREE,    POOL_LAST,     1'b0, ANY_RESULT},
            '{MODE_FREE,    POOL_LAST,     1'b0, ANY_RESULT}, // reaches zero, pushed
            '{MODE_FREE,    POOL_LAST,     1'b1, R_UNDER},
            '{MODE_ALLOC,   POOL_LAST,     1'b0, ANY_RESULT},
            '{MODE_SEED,    POOL_LAST,     1'b0, ANY_RESULT}, // seed of a page in use
            '{MODE_ALLOC,   POOL_FIRST,    1'b0, ANY_RESULT},
            '{MODE_ALLOC,   POOL_FIRST,    1'b0, ANY_RESULT},
            '{MODE_ALLOC,   POOL_FIRST,    1'b1, R_EMPTY}
        };

        model_cfg.mem_base_page   = MEM_BASE_RST;
        model_cfg.kernel_end_page = KEND_RST;
        model_cfg.top_page        = TOP_RST;
        foreach (page_refs[i]) page_refs[i] = '0;
        free_depth = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Registers answer during the clearing pass; check the reset values
        cfg_verify(REG_MEM_BASE, MEM_BASE_RST);
        cfg_verify(REG_KERNEL_END, KEND_RST);
        cfg_verify(REG_TOP, TOP_RST);

        idle_on = 1'b1;
        foreach (probe_table[k]) begin
            push_item(probe_table[k].mode, probe_table[k].addr,
                      probe_table[k].known, probe_table[k].want);
        end

        // Reset settings: random traffic, one long hold-off, one saturated page
        push_mix(150);
        hold_off_req = 1'b1;
        push_mix(80);
        sat_addr = valid_page_addr();
        repeat (int'(COUNT_MAX) + 2) push_item(MODE_REFUP, sat_addr, 1'b0, ANY_RESULT);
        repeat (int'(COUNT_MAX) + 1) push_item(MODE_FREE, sat_addr, 1'b0, ANY_RESULT);
        push_mix(100);

        // Table at page zero, nothing reserved, top at its maximum
        set_config(0, 0, TOP_LIMIT);
        push_mix(200);

        // Only the highest page is valid, as the last table entry
        set_config(1015808, 1048575, TOP_LIMIT);
        push_mix(120);

        // Base at its maximum: pages left on the list wrap page_addr
        set_config(1048575, 0, TOP_LIMIT);
        push_mix(100);

        // Kernel end above top: every address is rejected
        set_config(0, 1048575, 0);
        push_mix(50);

        repeat (3) begin
            base = $urandom_range(0, 1048575);
            kend = base + $urandom_range(0, 64);
            if (kend > 1048575) kend = 1048575;
            top = kend + $urandom_range(1, 40000);
            if (top > TOP_LIMIT) top = TOP_LIMIT;
            set_config(base, kend, top);
            push_mix(100);
        end

        // Last part, no idling on either side
        set_config(MEM_BASE_RST, KEND_RST, TOP_RST);
        idle_on = 1'b0;
        push_mix(20);

        settle();
        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run, clearing pass included
    initial begin : watchdog
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
sv/rcpa_pkg.sv
sv/rcpa_ram.sv
sv/rcpa_front.sv
sv/rcpa_queue.sv
sv/rcpa_back.sv
sv/refcounted_page_allocator_unit.sv
dv/refcounted_page_allocator_unit_test.sv
